// ===== hdl/pdc_pkg.sv =====
`timescale 1ns / 1ps
// Package for the pump dose controller: codes, item kinds, queue and result types,
// and the reciprocal constants of the digit pipeline. No dependencies.
package pdc_pkg;

    localparam int DEF_CLICK_SCALE = 30;
    localparam logic [15:0] DEF_FWD_LEVEL = 16'd30000;
    localparam logic [15:0] DEF_BWD_LEVEL = 16'd15000;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_FWD_LEVEL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BWD_LEVEL = 1'd1;

    localparam logic [1:0] FUNC_CMD  = 2'd0;
    localparam logic [1:0] FUNC_EDGE = 2'd1;
    localparam logic [1:0] FUNC_TICK = 2'd2;

    localparam logic [7:0] CHR_P = 8'h50;
    localparam logic [7:0] CHR_V = 8'h56;
    localparam logic [7:0] CHR_I = 8'h49;
    localparam logic [7:0] CHR_Q = 8'h51;
    localparam logic [7:0] CHR_S = 8'h53;
    localparam logic [7:0] CHR_F = 8'h46;
    localparam logic [7:0] CHR_B = 8'h42;
    localparam logic [7:0] CHR_C = 8'h43;
    localparam logic [7:0] CHR_O = 8'h4F;
    localparam logic [7:0] CHR_K = 8'h6B;
    localparam logic [7:0] DIGIT_BASE = 8'h30;

    localparam int NUM_W = 10;
    localparam int DIV_SHIFT = 24;
    localparam int RECIP_10 = (1 << DIV_SHIFT) / 10 + 1;
    localparam int RECIP_10_W = 21;
    localparam int Q10_W  = 13;
    localparam int Q100_W = 10;

    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_BWD  = 2'd2
    } t_dir;

    typedef enum logic [3:0] {
        K_NOP,
        K_SET,
        K_VALVE_CLOSE,
        K_VALVE_OPEN,
        K_VALVE_STATUS,
        K_IDENT,
        K_QUERY,
        K_STOP,
        K_ECHO,
        K_EDGE,
        K_TICK
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        t_dir             dir;
        logic             dir_ok;
        logic [NUM_W-1:0] num;
        logic [7:0]       b0;
        logic [7:0]       b1;
        logic [7:0]       b2;
    } t_entry;

    typedef struct packed {
        logic [15:0] level;
        logic        led;
        logic        valve;
        logic        pumping;
        logic [1:0]  rlen;
        logic [7:0]  rep0;
        logic [7:0]  rep1;
        logic [7:0]  rep2;
    } t_res;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_qword;

endpackage

// ===== hdl/pdc_in_if.sv =====
`timescale 1ns / 1ps
// Input channel of the pump dose controller: valid, ready and one item word.
// No dependencies.
interface pdc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] cmd_byte;
    logic [7:0] sub_byte;
    logic [7:0] hundreds_byte;
    logic [7:0] tens_byte;
    logic [7:0] ones_byte;

    modport source (output valid, func, cmd_byte, sub_byte, hundreds_byte, tens_byte,
                    ones_byte, input ready);
    modport sink (input valid, func, cmd_byte, sub_byte, hundreds_byte, tens_byte,
                  ones_byte, output ready);
endinterface

// ===== hdl/pdc_out_if.sv =====
`timescale 1ns / 1ps
// Result channel of the pump dose controller: valid, ready and one result word.
// No dependencies.
interface pdc_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] motor_level;
    logic        led_on;
    logic        valve_closed;
    logic        pumping;
    logic [1:0]  reply_length;
    logic [7:0]  reply_first;
    logic [7:0]  reply_second;
    logic [7:0]  reply_third;

    modport source (output valid, motor_level, led_on, valve_closed, pumping,
                    reply_length, reply_first, reply_second, reply_third, input ready);
    modport sink (input valid, motor_level, led_on, valve_closed, pumping,
                  reply_length, reply_first, reply_second, reply_third, output ready);
endinterface

// ===== hdl/pdc_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts input words and classifies them into queue entries.
// Depends on pdc_pkg and pdc_in_if.
module pdc_front import pdc_pkg::*; (
    pdc_in_if.sink   i_cmd,
    input  logic     i_q_ready,
    output t_qword   o_qword
);

    function automatic logic [3:0] digit_of(input logic [7:0] b);
        logic [3:0] d;
        case (b) inside
            [8'h30:8'h39]: d = 4'(b - DIGIT_BASE);
            default:       d = 4'd0;
        endcase
        return d;
    endfunction

    t_entry w_e;

    assign i_cmd.ready = i_q_ready;

    always_comb begin
        w_e.kind   = K_NOP;
        w_e.dir    = DIR_STOP;
        w_e.dir_ok = 1'b0;
        w_e.num    = NUM_W'(10'(digit_of(i_cmd.hundreds_byte)) * 10'd100
                          + 10'(digit_of(i_cmd.tens_byte)) * 10'd10
                          + 10'(digit_of(i_cmd.ones_byte)));
        w_e.b0     = i_cmd.cmd_byte;
        w_e.b1     = i_cmd.sub_byte;
        w_e.b2     = i_cmd.hundreds_byte;
        case (i_cmd.sub_byte)
            CHR_F: begin
                w_e.dir    = DIR_FWD;
                w_e.dir_ok = 1'b1;
            end
            CHR_B: begin
                w_e.dir    = DIR_BWD;
                w_e.dir_ok = 1'b1;
            end
            CHR_S: begin
                w_e.dir    = DIR_STOP;
                w_e.dir_ok = 1'b1;
            end
            default: ;
        endcase
        case (i_cmd.func)
            FUNC_CMD: begin
                case (i_cmd.cmd_byte)
                    CHR_P: w_e.kind = K_SET;
                    CHR_V: begin
                        case (i_cmd.sub_byte)
                            CHR_C:   w_e.kind = K_VALVE_CLOSE;
                            CHR_O:   w_e.kind = K_VALVE_OPEN;
                            CHR_S:   w_e.kind = K_VALVE_STATUS;
                            default: w_e.kind = K_NOP;
                        endcase
                    end
                    CHR_I:   w_e.kind = K_IDENT;
                    CHR_Q:   w_e.kind = K_QUERY;
                    CHR_S:   w_e.kind = K_STOP;
                    default: w_e.kind = K_ECHO;
                endcase
            end
            FUNC_EDGE: w_e.kind = K_EDGE;
            FUNC_TICK: w_e.kind = K_TICK;
            default:   w_e.kind = K_NOP;
        endcase
    end

    assign o_qword.valid = i_cmd.valid && i_q_ready;
    assign o_qword.entry = w_e;

endmodule

// ===== hdl/pdc_queue.sv =====
`timescale 1ns / 1ps
// Two-entry queue between the front end and the execution back end.
// Depends on pdc_pkg.
module pdc_queue import pdc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_qword i_push,
    output logic   o_ready,
    input  logic   i_pop,
    output t_qword o_head
);

    t_entry     r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       w_pop;

    assign o_ready      = (r_cnt != 2'd2);
    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.entry = r_mem[r_rd];
    assign w_pop        = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push.valid) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(i_push.valid) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr] <= i_push.entry;
        end
    end

endmodule

// ===== hdl/pdc_back.sv =====
`timescale 1ns / 1ps
// Back end: executes queue entries against the pump state and forms the reply,
// with a reciprocal-multiply pipeline for the remaining-count digits.
// Depends on pdc_pkg and pdc_out_if.
module pdc_back import pdc_pkg::*; #(
    parameter int CLICK_SCALE = DEF_CLICK_SCALE
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_qword                i_head,
    output logic                  o_pop,
    pdc_out_if.source             o_res
);

    localparam int RECIP   = (1 << DIV_SHIFT) / CLICK_SCALE + 1;
    localparam int RECIP_W = DIV_SHIFT + 1;
    localparam int P2_W    = 16 + RECIP_W;
    localparam int P3_W    = 16 + RECIP_10_W;
    localparam int P4_W    = Q10_W + RECIP_10_W;

    logic [15:0] r_fwd_level, r_bwd_level;
    logic        r_run, r_halted, r_valve, r_led;
    t_dir        r_tdir, r_speed, r_motor;
    logic [15:0] r_count, r_target;

    logic        n_run, n_halted, n_valve, n_led;
    t_dir        n_tdir, n_speed, n_motor;
    logic [15:0] n_count, n_target;

    logic        w_en;
    t_res        w_s1;
    logic        w_q1;
    logic [15:0] w_d1;
    logic [16:0] w_inc;
    t_entry      w_e;

    logic        r_v1, r_v2, r_v3, r_v4, r_out_valid;
    t_res        r_s1, r_s2, r_s3, r_s4, r_out;
    logic        r_q1, r_q2, r_q3, r_q4;
    logic [15:0] r_d1, r_v2_val;
    logic [7:0]  r_v3_lo;
    logic [Q10_W-1:0] r_q10_3;
    logic [7:0]  r_q10_4, r_q100_4, r_ones_4;

    logic [P2_W-1:0] w_p2;
    logic [P3_W-1:0] w_p3;
    logic [P4_W-1:0] w_p4;
    t_res        w_out;

    assign w_en  = !r_out_valid || o_res.ready;
    assign o_pop = w_en;
    assign w_e   = i_head.entry;
    assign w_inc = {1'b0, r_count} + 17'd1;

    always_comb begin
        n_run    = r_run;
        n_halted = r_halted;
        n_valve  = r_valve;
        n_led    = r_led;
        n_tdir   = r_tdir;
        n_speed  = r_speed;
        n_motor  = r_motor;
        n_count  = r_count;
        n_target = r_target;
        w_s1     = '0;
        w_q1     = 1'b0;
        w_d1     = r_target - r_count;
        case (w_e.kind)
            K_SET: begin
                n_run    = 1'b1;
                n_count  = 16'd0;
                n_halted = 1'b0;
                if (w_e.dir_ok) begin
                    n_tdir = w_e.dir;
                end
                n_target = 16'(32'(w_e.num) * 32'(CLICK_SCALE));
            end
            K_VALVE_CLOSE: n_valve = 1'b1;
            K_VALVE_OPEN:  n_valve = 1'b0;
            K_VALVE_STATUS: begin
                w_s1.rlen = 2'd3;
                w_s1.rep0 = DIGIT_BASE;
                w_s1.rep1 = DIGIT_BASE;
                w_s1.rep2 = DIGIT_BASE | {7'd0, r_valve};
            end
            K_IDENT: begin
                w_s1.rlen = 2'd2;
                w_s1.rep0 = CHR_O;
                w_s1.rep1 = CHR_K;
            end
            K_QUERY: begin
                w_s1.rlen = 2'd3;
                w_q1      = 1'b1;
            end
            K_STOP: begin
                n_halted = 1'b1;
                n_run    = 1'b0;
                n_speed  = DIR_STOP;
            end
            K_ECHO: begin
                w_s1.rlen = 2'd3;
                w_s1.rep0 = w_e.b0;
                w_s1.rep1 = w_e.b1;
                w_s1.rep2 = w_e.b2;
            end
            K_EDGE: begin
                if (w_inc[15:0] > r_target) begin
                    n_run    = 1'b0;
                    n_count  = 16'd0;
                    n_target = 16'd0;
                    n_tdir   = DIR_STOP;
                    n_halted = 1'b1;
                end else begin
                    n_count = w_inc[15:0];
                end
            end
            K_TICK: begin
                n_motor = r_speed;
                if (r_speed == DIR_STOP) begin
                    n_run = 1'b0;
                    n_led = 1'b1;
                end else begin
                    n_led = ~r_led;
                end
            end
            default: ;
        endcase
        if (!n_halted && n_run) begin
            n_speed = n_tdir;
        end
        if (n_halted) begin
            n_led   = 1'b1;
            n_run   = 1'b0;
            n_speed = DIR_STOP;
            n_motor = DIR_STOP;
        end
        case (n_motor)
            DIR_FWD: w_s1.level = r_fwd_level;
            DIR_BWD: w_s1.level = r_bwd_level;
            default: w_s1.level = 16'd0;
        endcase
        w_s1.led     = n_led;
        w_s1.valve   = n_valve;
        w_s1.pumping = n_run;
    end

    assign w_p2 = P2_W'(r_d1) * P2_W'(RECIP);
    assign w_p3 = P3_W'(r_v2_val) * P3_W'(RECIP_10);
    assign w_p4 = P4_W'(r_q10_3) * P4_W'(RECIP_10);

    always_comb begin
        w_out = r_s4;
        if (r_q4) begin
            w_out.rep0 = r_q100_4 + DIGIT_BASE;
            w_out.rep1 = 8'(r_q10_4 - 8'(r_q100_4 * 8'd10)) + DIGIT_BASE;
            w_out.rep2 = r_ones_4 + DIGIT_BASE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_level <= DEF_FWD_LEVEL;
            r_bwd_level <= DEF_BWD_LEVEL;
            r_run       <= 1'b0;
            r_halted    <= 1'b1;
            r_valve     <= 1'b0;
            r_led       <= 1'b1;
            r_tdir      <= DIR_STOP;
            r_speed     <= DIR_STOP;
            r_motor     <= DIR_STOP;
            r_count     <= 16'd0;
            r_target    <= 16'd0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FWD_LEVEL: r_fwd_level <= i_cfg_data;
                    CFG_BWD_LEVEL: r_bwd_level <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_en) begin
                r_v1        <= i_head.valid;
                r_v2        <= r_v1;
                r_v3        <= r_v2;
                r_v4        <= r_v3;
                r_out_valid <= r_v4;
                if (i_head.valid) begin
                    r_run    <= n_run;
                    r_halted <= n_halted;
                    r_valve  <= n_valve;
                    r_led    <= n_led;
                    r_tdir   <= n_tdir;
                    r_speed  <= n_speed;
                    r_motor  <= n_motor;
                    r_count  <= n_count;
                    r_target <= n_target;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1     <= w_s1;
            r_q1     <= w_q1;
            r_d1     <= w_d1;
            r_s2     <= r_s1;
            r_q2     <= r_q1;
            r_v2_val <= w_p2[DIV_SHIFT +: 16];
            r_s3     <= r_s2;
            r_q3     <= r_q2;
            r_v3_lo  <= r_v2_val[7:0];
            r_q10_3  <= w_p3[DIV_SHIFT +: Q10_W];
            r_s4     <= r_s3;
            r_q4     <= r_q3;
            r_q10_4  <= r_q10_3[7:0];
            r_q100_4 <= 8'(w_p4[DIV_SHIFT +: Q100_W]);
            r_ones_4 <= 8'(r_v3_lo - 8'(r_q10_3[7:0] * 8'd10));
            r_out    <= w_out;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.motor_level  = r_out.level;
    assign o_res.led_on       = r_out.led;
    assign o_res.valve_closed = r_out.valve;
    assign o_res.pumping      = r_out.pumping;
    assign o_res.reply_length = r_out.rlen;
    assign o_res.reply_first  = r_out.rep0;
    assign o_res.reply_second = r_out.rep1;
    assign o_res.reply_third  = r_out.rep2;

    a_halted_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |-> (!r_run && r_led && r_speed == DIR_STOP && r_motor == DIR_STOP))
        else $error("halted pump still shows drive state");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_halted |-> (r_count <= r_target))
        else $error("click count passed target without halting");

    a_pipe_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r_v4) |=> r_out_valid)
        else $error("result word lost between last stage and output register");

endmodule

// ===== hdl/pump_dose_controller.sv =====
`timescale 1ns / 1ps
// Pump dose controller top level: front end, two-entry queue and back end.
// Depends on pdc_pkg, pdc_in_if, pdc_out_if, pdc_front, pdc_queue and pdc_back.
// The controller takes one word per clock and returns exactly one result word for
// each, in order. An accepted word is written into the queue; the execute stage
// takes it as it leaves the queue, three stages of reciprocal multiplication turn
// the remaining count into decimal digits, and the output register presents the
// result word. Throughput is one word per cycle while the result side takes words;
// a stalled output holds the whole back end and the two-entry queue absorbs up to
// two more input words before ready drops.
module pump_dose_controller import pdc_pkg::*; #(
    parameter int CLICK_SCALE = DEF_CLICK_SCALE
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pdc_in_if.sink                i_cmd,
    pdc_out_if.source             o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_qword w_push;
    t_qword w_head;
    logic   w_q_ready;
    logic   w_pop;

    pdc_front u_front (
        .i_cmd     (i_cmd),
        .i_q_ready (w_q_ready),
        .o_qword   (w_push)
    );

    pdc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_ready (w_q_ready),
        .i_pop   (w_pop),
        .o_head  (w_head)
    );

    pdc_back #(
        .CLICK_SCALE (CLICK_SCALE)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_head     (w_head),
        .o_pop      (w_pop),
        .o_res      (o_res)
    );

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for pump_dose_controller: a directed table, then random dose
// sequences and noise words, each result checked against its table entry or an in-bench predictor.
// Depends on pdc_pkg, pdc_in_if, pdc_out_if and the pump_dose_controller RTL.
module tb_top;
    import pdc_pkg::*;

    localparam int SCALE = DEF_CLICK_SCALE;
    localparam logic [1:0] FUNC_NONE = 2'd3;
    localparam int PHASES = 6;
    localparam int PHASE_WORDS = 305;
    localparam int SETTLE_CYCLES = 10;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] cmd;
        logic [7:0] sub;
        logic [7:0] hun;
        logic [7:0] ten;
        logic [7:0] one;
    } t_cmd_word;

    typedef struct {
        t_cmd_word w;
        bit        known;
        t_res      want;
    } t_dose_step;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    pdc_in_if  cmd_if ();
    pdc_out_if res_if ();

    pump_dose_controller dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd_if),
        .o_res      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    logic [15:0] p_fwd = DEF_FWD_LEVEL;
    logic [15:0] p_bwd = DEF_BWD_LEVEL;
    logic        p_run = 1'b0;
    logic        p_halted = 1'b1;
    t_dir        p_dir = DIR_STOP;
    t_dir        p_speed = DIR_STOP;
    t_dir        p_motor = DIR_STOP;
    logic [15:0] p_clicks = 16'd0;
    logic [15:0] p_target = 16'd0;
    logic        p_valve = 1'b0;
    logic        p_led = 1'b1;

    t_res       status_q[$];
    t_dose_step directed_q[$];
    int         words_sent = 0;
    int         errors = 0;
    int         stall_left = 0;
    bit         src_idle_on = 1'b1;
    bit         sink_idle_on = 1'b1;

    function automatic t_res mk_res(logic [15:0] lvl, logic led, logic valve, logic pump,
                                    logic [1:0] rl, logic [7:0] a, logic [7:0] b,
                                    logic [7:0] c);
        t_res r;
        r.level = lvl;
        r.led = led;
        r.valve = valve;
        r.pumping = pump;
        r.rlen = rl;
        r.rep0 = a;
        r.rep1 = b;
        r.rep2 = c;
        return r;
    endfunction

    function automatic t_cmd_word mk_word(logic [1:0] func, logic [7:0] cmd, logic [7:0] sub,
                                          logic [7:0] hun, logic [7:0] ten, logic [7:0] one);
        t_cmd_word w;
        w.func = func;
        w.cmd = cmd;
        w.sub = sub;
        w.hun = hun;
        w.ten = ten;
        w.one = one;
        return w;
    endfunction

    function automatic logic [7:0] ascii_digit(int v);
        return 8'(v + int'(DIGIT_BASE));
    endfunction

    function automatic logic [23:0] ascii_triplet(int v);
        return {ascii_digit(v / 100), ascii_digit((v / 10) % 10), ascii_digit(v % 10)};
    endfunction

    function automatic int digit_val(logic [7:0] b);
        if (b >= DIGIT_BASE && b <= DIGIT_BASE + 8'd9) begin
            return int'(b - DIGIT_BASE);
        end
        return 0;
    endfunction

    function automatic t_res predict_status(t_cmd_word w);
        logic [1:0]  rl;
        logic [23:0] rep;
        logic [15:0] rem;
        logic [15:0] lvl;
        int n;
        rl = 2'd0;
        rep = 24'd0;
        case (w.func)
            FUNC_CMD: begin
                if (w.cmd == CHR_P) begin
                    n = digit_val(w.hun) * 100 + digit_val(w.ten) * 10 + digit_val(w.one);
                    p_run = 1'b1;
                    p_clicks = 16'd0;
                    p_halted = 1'b0;
                    if (w.sub == CHR_F) begin
                        p_dir = DIR_FWD;
                    end else if (w.sub == CHR_B) begin
                        p_dir = DIR_BWD;
                    end else if (w.sub == CHR_S) begin
                        p_dir = DIR_STOP;
                    end
                    p_target = 16'(SCALE * n);
                end else if (w.cmd == CHR_V) begin
                    if (w.sub == CHR_C) begin
                        p_valve = 1'b1;
                    end else if (w.sub == CHR_O) begin
                        p_valve = 1'b0;
                    end else if (w.sub == CHR_S) begin
                        rep = ascii_triplet(int'(p_valve));
                        rl = 2'd3;
                    end
                end else if (w.cmd == CHR_I) begin
                    rep = {CHR_O, CHR_K, 8'd0};
                    rl = 2'd2;
                end else if (w.cmd == CHR_Q) begin
                    rem = p_target - p_clicks;
                    rep = ascii_triplet(int'(rem) / SCALE);
                    rl = 2'd3;
                end else if (w.cmd == CHR_S) begin
                    p_halted = 1'b1;
                    p_run = 1'b0;
                    p_speed = DIR_STOP;
                end else begin
                    rep = {w.cmd, w.sub, w.hun};
                    rl = 2'd3;
                end
            end
            FUNC_EDGE: begin
                p_clicks = p_clicks + 16'd1;
                if (p_clicks > p_target) begin
                    p_run = 1'b0;
                    p_clicks = 16'd0;
                    p_target = 16'd0;
                    p_dir = DIR_STOP;
                    p_halted = 1'b1;
                end
            end
            FUNC_TICK: begin
                p_motor = p_speed;
                if (p_speed == DIR_STOP) begin
                    p_run = 1'b0;
                    p_led = 1'b1;
                end else begin
                    p_led = ~p_led;
                end
            end
            default: begin
            end
        endcase
        if (!p_halted && p_run) begin
            p_speed = p_dir;
        end
        if (p_halted) begin
            p_led = 1'b1;
            p_run = 1'b0;
            p_speed = DIR_STOP;
            p_motor = DIR_STOP;
        end
        lvl = (p_motor == DIR_FWD) ? p_fwd : (p_motor == DIR_BWD) ? p_bwd : 16'd0;
        return mk_res(lvl, p_led, p_valve, p_run, rl, rep[23:16], rep[15:8], rep[7:0]);
    endfunction

    function automatic t_cmd_word random_word(logic [1:0] func);
        return mk_word(func, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)));
    endfunction

    function automatic t_cmd_word dose_word(logic [7:0] sub, int n);
        logic [7:0] d[3];
        d[0] = ascii_digit(n / 100);
        d[1] = ascii_digit((n / 10) % 10);
        d[2] = ascii_digit(n % 10);
        foreach (d[i]) begin
            if ($urandom_range(0, 9) == 0) begin
                d[i] = 8'($urandom_range(0, 255));
            end
        end
        return mk_word(FUNC_CMD, CHR_P, sub, d[0], d[1], d[2]);
    endfunction

    function automatic t_cmd_word valve_word();
        t_cmd_word w;
        w = random_word(FUNC_CMD);
        w.cmd = CHR_V;
        case ($urandom_range(0, 3))
            0: w.sub = CHR_C;
            1: w.sub = CHR_O;
            2: w.sub = CHR_S;
            default: begin
            end
        endcase
        return w;
    endfunction

    function automatic t_cmd_word noise_word();
        t_cmd_word w;
        int k;
        k = $urandom_range(0, 99);
        w = random_word(FUNC_CMD);
        if (k < 30) begin
            w.func = FUNC_EDGE;
        end else if (k < 50) begin
            w.func = FUNC_TICK;
        end else if (k < 54) begin
            w.func = FUNC_NONE;
        end else if (k < 62) begin
            w = dose_word(w.sub, $urandom_range(0, 999));
        end else if (k < 70) begin
            w.cmd = CHR_Q;
        end else if (k < 78) begin
            w = valve_word();
        end else if (k < 84) begin
            w.cmd = CHR_I;
        end else if (k < 90) begin
            w.cmd = CHR_S;
        end
        return w;
    endfunction

    task automatic add_step(t_cmd_word w, bit known, t_res want);
        t_dose_step s;
        s.w = w;
        s.known = known;
        s.want = want;
        directed_q.push_back(s);
    endtask

    task automatic send_word(t_cmd_word w, bit known, t_res want);
        t_res predicted;
        if (src_idle_on && $urandom_range(0, 4) == 0) begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.func <= w.func;
        cmd_if.cmd_byte <= w.cmd;
        cmd_if.sub_byte <= w.sub;
        cmd_if.hundreds_byte <= w.hun;
        cmd_if.tens_byte <= w.ten;
        cmd_if.ones_byte <= w.one;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        predicted = predict_status(w);
        status_q.push_back(known ? want : predicted);
        words_sent++;
    endtask

    task automatic run_dose_sequence();
        t_cmd_word w;
        logic [7:0] sub;
        int n;
        int k;
        int len;
        k = $urandom_range(0, 9);
        sub = (k < 4) ? CHR_F : (k < 8) ? CHR_B : (k == 8) ? CHR_S : 8'($urandom_range(0, 255));
        k = $urandom_range(0, 19);
        n = (k < 10) ? 0 : (k < 16) ? 1 : (k < 19) ? 2 : $urandom_range(0, 999);
        send_word(dose_word(sub, n), 1'b0, '0);
        len = 0;
        while (!p_halted && len < 90) begin
            k = $urandom_range(0, 19);
            if (k < 12) begin
                w = random_word(FUNC_EDGE);
            end else if (k < 17) begin
                w = random_word(FUNC_TICK);
            end else if (k == 17 || k == 18) begin
                w = random_word(FUNC_CMD);
                w.cmd = CHR_Q;
            end else begin
                w = valve_word();
            end
            send_word(w, 1'b0, '0);
            len++;
        end
        if (!p_halted) begin
            w = random_word(FUNC_CMD);
            w.cmd = CHR_S;
            send_word(w, 1'b0, '0);
        end
    endtask

    task automatic drain_results();
        cmd_if.valid <= 1'b0;
        while (status_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_levels(logic [15:0] fwd, logic [15:0] bwd);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_FWD_LEVEL;
        i_cfg_data <= fwd;
        @(posedge i_clk);
        i_cfg_idx <= CFG_BWD_LEVEL;
        i_cfg_data <= bwd;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        p_fwd = fwd;
        p_bwd = bwd;
    endtask

    task automatic note_mismatch(string what, logic [15:0] got, logic [15:0] want);
        errors++;
        $display("%0t ERROR %s: got %h, expected %h", $realtime, what, got, want);
    endtask

    task automatic check_status();
        t_res want;
        if (status_q.size() == 0) begin
            note_mismatch("word with nothing expected", 16'd0, 16'd0);
            return;
        end
        want = status_q.pop_front();
        if (res_if.motor_level !== want.level)
            note_mismatch("motor_level", res_if.motor_level, want.level);
        if (res_if.led_on !== want.led)
            note_mismatch("led_on", 16'(res_if.led_on), 16'(want.led));
        if (res_if.valve_closed !== want.valve)
            note_mismatch("valve_closed", 16'(res_if.valve_closed), 16'(want.valve));
        if (res_if.pumping !== want.pumping)
            note_mismatch("pumping", 16'(res_if.pumping), 16'(want.pumping));
        if (res_if.reply_length !== want.rlen)
            note_mismatch("reply_length", 16'(res_if.reply_length), 16'(want.rlen));
        if (res_if.reply_first !== want.rep0)
            note_mismatch("reply_first", 16'(res_if.reply_first), 16'(want.rep0));
        if (res_if.reply_second !== want.rep1)
            note_mismatch("reply_second", 16'(res_if.reply_second), 16'(want.rep1));
        if (res_if.reply_third !== want.rep2)
            note_mismatch("reply_third", 16'(res_if.reply_third), 16'(want.rep2));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            check_status();
        end
        if (stall_left > 0) begin
            res_if.ready <= 1'b0;
            stall_left = stall_left - 1;
        end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
            res_if.ready <= 1'b0;
            stall_left = $urandom_range(0, 2);
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    initial begin
        #5000000;
        $display("pump_dose_controller: mismatch");
        $finish;
    end

    initial begin
        int phase;
        int phase_end;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_FWD_LEVEL;
        i_cfg_data = '0;
        cmd_if.valid = 1'b0;
        cmd_if.func = FUNC_CMD;
        cmd_if.cmd_byte = 8'd0;
        cmd_if.sub_byte = 8'd0;
        cmd_if.hundreds_byte = 8'd0;
        cmd_if.tens_byte = 8'd0;
        cmd_if.ones_byte = 8'd0;
        res_if.ready = 1'b0;

        add_step(mk_word(FUNC_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0), 1'b1,
                 mk_res(16'd0, 1'b1, 1'b0, 1'b0, 2'd0, 8'd0, 8'd0, 8'd0));
        add_step(mk_word(FUNC_CMD, CHR_I, 8'd0, 8'd0, 8'd0, 8'd0), 1'b1,
                 mk_res(16'd0, 1'b1, 1'b0, 1'b0, 2'd2, CHR_O, CHR_K, 8'd0));
        add_step(mk_word(FUNC_CMD, CHR_Q, 8'd0, 8'd0, 8'd0, 8'd0), 1'b1,
                 mk_res(16'd0, 1'b1, 1'b0, 1'b0, 2'd3, DIGIT_BASE, DIGIT_BASE, DIGIT_BASE));
        add_step(mk_word(FUNC_CMD, CHR_V, CHR_S, 8'd0, 8'd0, 8'd0), 1'b1,
                 mk_res(16'd0, 1'b1, 1'b0, 1'b0, 2'd3, DIGIT_BASE, DIGIT_BASE, DIGIT_BASE));
        add_step(mk_word(FUNC_CMD, CHR_V, CHR_C, 8'd0, 8'd0, 8'd0), 1'b1,
                 mk_res(16'd0, 1'b1, 1'b1, 1'b0, 2'd0, 8'd0, 8'd0, 8'd0));
        add_step(mk_word(FUNC_CMD, CHR_V, CHR_S, 8'd0, 8'd0, 8'd0), 1'b1,
                 mk_res(16'd0, 1'b1, 1'b1, 1'b0, 2'd3, DIGIT_BASE, DIGIT_BASE,
                        ascii_digit(1)));
        add_step(mk_word(FUNC_CMD, CHR_V, CHR_O, 8'd0, 8'd0, 8'd0), 1'b1,
                 mk_res(16'd0, 1'b1, 1'b0, 1'b0, 2'd0, 8'd0, 8'd0, 8'd0));
        add_step(mk_word(FUNC_CMD, CHR_V, 8'hA5, 8'd0, 8'd0, 8'd0), 1'b1,
                 mk_res(16'd0, 1'b1, 1'b0, 1'b0, 2'd0, 8'd0, 8'd0, 8'd0));
        add_step(mk_word(FUNC_CMD, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00), 1'b1,
                 mk_res(16'd0, 1'b1, 1'b0, 1'b0, 2'd3, 8'hFF, 8'h00, 8'hFF));
        add_step(mk_word(FUNC_CMD, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF), 1'b1,
                 mk_res(16'd0, 1'b1, 1'b0, 1'b0, 2'd3, 8'h00, 8'hFF, 8'h00));
        add_step(mk_word(FUNC_CMD, CHR_P, CHR_F, ascii_digit(9), ascii_digit(9),
                         ascii_digit(9)), 1'b1,
                 mk_res(16'd0, 1'b1, 1'b0, 1'b1, 2'd0, 8'd0, 8'd0, 8'd0));
        add_step(mk_word(FUNC_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0), 1'b1,
                 mk_res(DEF_FWD_LEVEL, 1'b0, 1'b0, 1'b1, 2'd0, 8'd0, 8'd0, 8'd0));
        add_step(mk_word(FUNC_CMD, CHR_Q, 8'd0, 8'd0, 8'd0, 8'd0), 1'b1,
                 mk_res(DEF_FWD_LEVEL, 1'b0, 1'b0, 1'b1, 2'd3, ascii_digit(9),
                        ascii_digit(9), ascii_digit(9)));
        add_step(mk_word(FUNC_EDGE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b0, '0);
        add_step(mk_word(FUNC_CMD, CHR_Q, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b0, '0);
        add_step(mk_word(FUNC_CMD, CHR_P, CHR_B, 8'h2F, 8'h3A, 8'hFF), 1'b0, '0);
        add_step(mk_word(FUNC_TICK, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b0, '0);
        add_step(mk_word(FUNC_EDGE, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0), 1'b0, '0);
        add_step(mk_word(FUNC_CMD, CHR_P, 8'h5A, DIGIT_BASE, DIGIT_BASE, ascii_digit(5)),
                 1'b0, '0);
        add_step(mk_word(FUNC_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0), 1'b0, '0);
        add_step(mk_word(FUNC_CMD, CHR_P, CHR_S, ascii_digit(1), ascii_digit(2),
                         ascii_digit(3)), 1'b0, '0);
        add_step(mk_word(FUNC_CMD, CHR_S, 8'd0, 8'd0, 8'd0, 8'd0), 1'b0, '0);
        add_step(mk_word(FUNC_CMD, CHR_P, CHR_F, DIGIT_BASE, ascii_digit(9),
                         ascii_digit(9)), 1'b0, '0);
        add_step(mk_word(FUNC_NONE, CHR_I, 8'd0, 8'd0, 8'd0, 8'd0), 1'b0, '0);
        add_step(mk_word(FUNC_CMD, CHR_S, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b0, '0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_q[i]) begin
            send_word(directed_q[i].w, directed_q[i].known, directed_q[i].want);
        end

        for (phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) begin
                drain_results();
                case (phase)
                    1: write_levels(16'd0, 16'hFFFF);
                    2: write_levels(16'hFFFF, 16'd0);
                    default: write_levels(16'($urandom_range(0, 65535)),
                                          16'($urandom_range(0, 65535)));
                endcase
            end
            if (phase == PHASES - 1) begin
                src_idle_on = 1'b0;
                sink_idle_on = 1'b0;
            end
            phase_end = words_sent + PHASE_WORDS;
            while (words_sent < phase_end) begin
                if ($urandom_range(0, 9) < 7) begin
                    run_dose_sequence();
                end else begin
                    send_word(noise_word(), 1'b0, '0);
                end
            end
        end

        drain_results();
        if (errors == 0) begin
            $display("pump_dose_controller: match");
        end else begin
            $display("pump_dose_controller: mismatch");
        end
        $finish;
    end
endmodule
